>>> rtl/core/s1md_pkg.sv
// Shared types, constants and helper functions for the SHA-1 digest unit.
// Used by the front queue, the compression core, the back controller and the top level.
// Has no dependencies.
package s1md_pkg;

   localparam int WORD_W      = 32;
   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_W     = 512;
   localparam int SCHED_WORDS = 16;
   localparam int ROUNDS      = 80;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] chain_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef struct packed {
      logic start;
      logic reinit;
   } cmp_ctl_type;

   typedef enum logic [2:0] {
      ST_DATA,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   function automatic chain_type init_chain();
      chain_type c;
      c[0] = 32'h67452301;
      c[1] = 32'hEFCDAB89;
      c[2] = 32'h98BADCFE;
      c[3] = 32'h10325476;
      c[4] = 32'hC3D2E1F0;
      return c;
   endfunction

   function automatic word_type round_k(input logic [6:0] round);
      word_type k;
      if (round < 7'd20) begin
         k = 32'h5A827999;
      end else if (round < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (round < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

>>> rtl/core/sha1_message_digest_unit.sv
// Flow: the back end packs each byte word into the current block; a full 64-byte block keeps
// the compression core busy. The byte that completes the next block waits until the core is
// free, so a long message is bound by the core. After the end word the padding bytes (up to
// 72) are written, each full padding block is compressed, the back end waits for the core to
// finish, then sends five digest words, one per cycle when the consumer is ready.
// Reset is synchronous and restores the initial chaining words and an empty message.
module sha1_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import s1md_pkg::*;

   item_type           req_item;
   logic               q_valid;
   item_type           q_item;
   logic               q_pop;
   cmp_ctl_type        cmp_ctl;
   logic [BLOCK_W-1:0] cmp_block;
   logic               cmp_busy;
   chain_type          chain;

   assign req_item.data_byte      = req_data_byte;
   assign req_item.byte_present   = req_byte_present;
   assign req_item.end_of_message = req_end_of_message;

   s1md_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   s1md_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctl   (cmp_ctl),
      .block (cmp_block),
      .busy  (cmp_busy),
      .chain (chain)
   );

   s1md_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .cmp_ctl         (cmp_ctl),
      .cmp_block       (cmp_block),
      .cmp_busy        (cmp_busy),
      .chain           (chain),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

>>> rtl/core/s1md_front.sv
// Front end of the SHA-1 digest unit: accepts request words and queues the ones
// that carry a byte or an end mark. Depends on s1md_pkg.
module s1md_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  s1md_pkg::item_type req_item,
   output logic               q_valid,
   output s1md_pkg::item_type q_item,
   input  logic               q_pop
);
   import s1md_pkg::*;

   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // Words with neither a byte nor an end mark change nothing and are dropped here.
   always_comb begin
      req_ready = (count_ff != 2'(QUEUE_DEPTH));
      push      = req_valid && req_ready &&
                  (req_item.byte_present || req_item.end_of_message);
      q_valid   = (count_ff != 2'd0);
      q_item    = entry_ff[rd_ff];
      pop       = q_pop && q_valid;
      wr_in     = push ? ~wr_ff : wr_ff;
      rd_in     = pop ? ~rd_ff : rd_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= req_item;
      end
   end

endmodule

>>> rtl/core/s1md_compress.sv
// SHA-1 compression core: one round per cycle with a rolling 16-word schedule,
// plus a final step to fold the result into the chaining words. Depends on s1md_pkg.
module s1md_compress (
   input  logic                        clock,
   input  logic                        reset,
   input  s1md_pkg::cmp_ctl_type       ctl,
   input  logic [s1md_pkg::BLOCK_W-1:0] block,
   output logic                        busy,
   output s1md_pkg::chain_type         chain
);
   import s1md_pkg::*;

   chain_type chain_ff, chain_in;
   word_type  w_ff [SCHED_WORDS];
   word_type  w_in [SCHED_WORDS];
   word_type  a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type  a_in, b_in, c_in, d_in, e_in;
   logic [6:0] round_ff, round_in;
   logic      busy_ff, busy_in;
   word_type  f;
   word_type  t;
   word_type  w_mix;

   always_comb begin
      chain_in = chain_ff;
      busy_in  = busy_ff;
      round_in = round_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      for (int i = 0; i < SCHED_WORDS; i++) begin
         w_in[i] = w_ff[i];
      end

      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
      end
      t     = {a_ff[26:0], a_ff[31:27]} + f + e_ff + round_k(round_ff) + w_ff[0];
      w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

      if (ctl.start) begin
         busy_in  = 1'b1;
         round_in = 7'd0;
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
         for (int i = 0; i < SCHED_WORDS; i++) begin
            w_in[i] = block[(SCHED_WORDS-1-i)*WORD_W +: WORD_W];
         end
      end else if (busy_ff && (round_ff == 7'(ROUNDS))) begin
         busy_in     = 1'b0;
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end else if (busy_ff) begin
         round_in = round_ff + 7'd1;
         a_in = t;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         for (int i = 0; i < SCHED_WORDS-1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[SCHED_WORDS-1] = {w_mix[30:0], w_mix[31]};
      end else if (ctl.reinit) begin
         chain_in = init_chain();
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chain_ff <= init_chain();
      end else begin
         busy_ff  <= busy_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      for (int i = 0; i < SCHED_WORDS; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   assign busy  = busy_ff;
   assign chain = chain_ff;

endmodule

>>> rtl/core/s1md_back.sv
// Back end of the SHA-1 digest unit: packs bytes into blocks, generates padding
// and the length trailer, and sends out the digest words. Depends on s1md_pkg.
module s1md_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  s1md_pkg::item_type           q_item,
   output logic                         q_pop,
   output s1md_pkg::cmp_ctl_type        cmp_ctl,
   output logic [s1md_pkg::BLOCK_W-1:0] cmp_block,
   input  logic                         cmp_busy,
   input  s1md_pkg::chain_type          chain,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_digest_word,
   output logic [2:0]                   rsp_word_index,
   output logic                         rsp_last_word
);
   import s1md_pkg::*;

   state_type          state_ff, state_in;
   logic [5:0]         pos_ff, pos_in;
   logic [63:0]        bits_ff, bits_in;
   logic [63:0]        len_ff, len_in;
   logic [2:0]         lcnt_ff, lcnt_in;
   logic [2:0]         widx_ff, widx_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_word_ff, rsp_word_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               can_put;
   logic               put_en;
   logic [7:0]         put_byte;

   always_comb begin
      state_in     = state_ff;
      bits_in      = bits_ff;
      len_in       = len_ff;
      lcnt_in      = lcnt_ff;
      widx_in      = widx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      put_en       = 1'b0;
      put_byte     = 8'h00;
      q_pop        = 1'b0;
      cmp_ctl      = '0;
      // The byte that completes a block must wait until the core is free.
      can_put      = !((pos_ff == 6'd63) && cmp_busy);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_DATA: begin
            if (q_valid && (!q_item.byte_present || can_put)) begin
               q_pop = 1'b1;
               if (q_item.byte_present) begin
                  put_en   = 1'b1;
                  put_byte = q_item.data_byte;
                  bits_in  = bits_ff + 64'd8;
               end
               if (q_item.end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (can_put) begin
               put_en   = 1'b1;
               put_byte = PAD_MARK;
               len_in   = bits_ff;
               lcnt_in  = 3'd0;
               state_in = (pos_ff == 6'd55) ? ST_LEN : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (can_put) begin
               put_en = 1'b1;
               if (pos_ff == 6'd55) begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (can_put) begin
               put_en   = 1'b1;
               put_byte = len_ff[63:56];
               len_in   = {len_ff[55:0], 8'h00};
               lcnt_in  = lcnt_ff + 3'd1;
               if (lcnt_ff == 3'd7) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!cmp_busy) begin
               widx_in  = 3'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain[widx_ff];
               rsp_idx_in   = widx_ff;
               rsp_last_in  = (widx_ff == LAST_INDEX);
               widx_in      = widx_ff + 3'd1;
               if (widx_ff == LAST_INDEX) begin
                  cmp_ctl.reinit = 1'b1;
                  bits_in        = 64'd0;
                  state_in       = ST_DATA;
               end
            end
         end
         default: begin
            state_in = ST_DATA;
         end
      endcase

      block_in      = put_en ? {block_ff[BLOCK_W-9:0], put_byte} : block_ff;
      pos_in        = put_en ? pos_ff + 6'd1 : pos_ff;
      cmp_ctl.start = put_en && (pos_ff == 6'd63);
      cmp_block     = block_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DATA;
         pos_ff       <= 6'd0;
         bits_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      lcnt_ff     <= lcnt_in;
      widx_ff     <= widx_in;
      block_ff    <= block_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmp_ctl.start |-> !cmp_busy)
      else $error("Compression started while the core was busy.");

   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (pos_ff >= 6'd56))
      else $error("Length trailer placed outside the last eight bytes of a block.");

   a_emit_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((pos_ff == 6'd0) && !cmp_busy))
      else $error("Digest sent before the final block was folded in.");

endmodule
